@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the block.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/saa_pkg.sv @@
// Types and constants of the spectrum align and accumulate block.
// No dependencies.
package saa_pkg;

    localparam int MZ_W  = 32;

    // request codes carried in the input tuser
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_APPLY = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // register selects, decoded from paddr[2]
    localparam logic REG_TOL = 1'b0;
    localparam logic REG_SUB = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LEFT,
        ST_ACC,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        ALU_DIFF,
        ALU_ACC_ADD,
        ALU_ACC_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [MZ_W-1:0]   a;
        logic [MZ_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [MZ_W-1:0]   result;
        logic              lt;
        logic              sat;
    } t_alu_res;

endpackage

@@ rtl/saa_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module saa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/saa_alu.sv @@
// Shared arithmetic unit: absolute m/z distance with order flag, and
// saturating intensity add or subtract. Depends on saa_pkg.
module saa_alu (
    input  saa_pkg::t_alu_req i_req,
    output saa_pkg::t_alu_res o_res
);

    logic [saa_pkg::MZ_W:0] diff;
    logic [saa_pkg::MZ_W:0] acc;
    logic [saa_pkg::MZ_W:0] a_ext;
    logic [saa_pkg::MZ_W:0] b_ext;

    assign diff  = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign a_ext = {i_req.a[saa_pkg::MZ_W-1], i_req.a};
    assign b_ext = {i_req.b[saa_pkg::MZ_W-1], i_req.b};

    always_comb begin
        o_res = '0;
        acc   = '0;
        case (i_req.op)
            saa_pkg::ALU_DIFF: begin
                o_res.lt     = diff[saa_pkg::MZ_W];
                o_res.result = diff[saa_pkg::MZ_W] ? (~diff[saa_pkg::MZ_W-1:0] + 1'b1)
                                                   : diff[saa_pkg::MZ_W-1:0];
            end
            saa_pkg::ALU_ACC_ADD, saa_pkg::ALU_ACC_SUB: begin
                acc = (i_req.op == saa_pkg::ALU_ACC_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
                // clamp when the carry-out sign disagrees with the result sign
                if (acc[saa_pkg::MZ_W] != acc[saa_pkg::MZ_W-1]) begin
                    o_res.sat    = 1'b1;
                    o_res.result = acc[saa_pkg::MZ_W]
                                 ? {1'b1, {(saa_pkg::MZ_W-1){1'b0}}}
                                 : {1'b0, {(saa_pkg::MZ_W-1){1'b1}}};
                end else begin
                    o_res.result = acc[saa_pkg::MZ_W-1:0];
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

@@ rtl/spectrum_align_accumulate.sv @@
// Top level of the spectrum align and accumulate block: sequencer, stores,
// configuration registers and output register. Depends on saa_pkg, saa_ram
// and saa_alu.
//
// Usage
//   Input channel (i_s_*): one beat per request. tuser carries the request
//   kind and the pass start flag, tdata the peak m/z and intensity.
//   Output channel (o_m_*): one beat per read of a stored reference peak,
//   tlast on the last stored peak, tuser the sticky saturate/drop flags.
//   APB port: tolerance at 0x0, subtract mode at 0x4; pready is tied high.
// Sequencing
//   Load and clear leave the sequencer idle. A read moves to the read state,
//   from which the registered store data enter the output register once it
//   is free. An apply is issued from idle; the walk state steps the pointer
//   over each reference peak below it and makes the stop compare, the left
//   state compares the left neighbour, and the acc state does the intensity
//   read-modify-write. Walk steps amortise to about one per neighbour peak
//   over a pass; the m/z store read port and the single shared ALU serialise them.
// Reset and stall
//   Reset clears counts, pointers, flags and the output register; the peak
//   stores stay undefined until loaded and need no clearing pass. While the
//   receiver stalls, the output beat holds; loads and applies go on, but a
//   further read waits for the output register to empty and blocks the input.
module spectrum_align_accumulate #(
    parameter int SCAN_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] peak_mz, [63:32] peak_intensity
    input  logic [2:0]  i_s_tuser,   // [1:0] req_type, [2] pass_start
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] out_mz, [63:32] out_intensity
    output logic        o_m_tlast,   // is_last
    output logic [1:0]  o_m_tuser,   // [0] saturated, [1] dropped
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(SCAN_DEPTH);
    localparam int CW = $clog2(SCAN_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SCAN_DEPTH);

    // configuration registers
    logic [31:0] r_tol;
    logic        r_sub;

    // sequencer state
    saa_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_walk, n_walk;
    logic            r_stopped, n_stopped;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic [CW-1:0]   r_rd_sel, n_rd_sel;
    logic            r_sat, n_sat;
    logic            r_drop, n_drop;
    logic [31:0]     r_mz, n_mz;
    logic [31:0]     r_int, n_int;
    logic [31:0]     r_rdist, n_rdist;
    logic [IW-1:0]   r_tgt, n_tgt;

    // output register
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_out_mz, n_out_mz;
    logic [31:0]     r_out_int, n_out_int;
    logic            r_out_last, n_out_last;
    logic            r_out_sat, n_out_sat;
    logic            r_out_drop, n_out_drop;

    // store ports
    logic            mz_we, int_we, mz_re, int_re;
    logic [IW-1:0]   mz_waddr, int_waddr, mz_raddr, int_raddr;
    logic [31:0]     int_wdata, mz_rdata, int_rdata;

    saa_pkg::t_alu_req alu_req;
    saa_pkg::t_alu_res alu_res;

    logic            in_acc;
    logic [1:0]      req;
    logic            pass_start;
    logic [CW-1:0]   app_walk;
    logic            app_stop;
    logic [CW-1:0]   walk_inc, walk_dec;
    logic [CW-1:0]   rd_sel_now, rd_sel_inc;

    assign req        = i_s_tuser[1:0];
    assign pass_start = i_s_tuser[2];
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == saa_pkg::ST_IDLE);

    // a pass start restarts the walk before the peak is looked at
    assign app_walk   = pass_start ? '0 : r_walk;
    assign app_stop   = pass_start ? 1'b0 : r_stopped;
    assign walk_inc   = r_walk + 1'b1;
    assign walk_dec   = r_walk - 1'b1;
    assign rd_sel_now = (r_rd_idx >= r_count) ? '0 : r_rd_idx;
    assign rd_sel_inc = r_rd_sel + 1'b1;

    // APB: writes on the access phase, reads straight from the registers
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            saa_pkg::REG_TOL: prdata = r_tol;
            saa_pkg::REG_SUB: prdata = {31'd0, r_sub};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 32'd6554;
            r_sub <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                saa_pkg::REG_TOL: r_tol <= pwdata;
                saa_pkg::REG_SUB: r_sub <= pwdata[0];
                default: ;
            endcase
        end
    end

    saa_ram #(.DEPTH(SCAN_DEPTH), .WIDTH(32)) u_mz_ram (
        .i_clk   (i_clk),
        .i_we    (mz_we),
        .i_waddr (mz_waddr),
        .i_wdata (i_s_tdata[31:0]),
        .i_re    (mz_re),
        .i_raddr (mz_raddr),
        .o_rdata (mz_rdata)
    );

    saa_ram #(.DEPTH(SCAN_DEPTH), .WIDTH(32)) u_int_ram (
        .i_clk   (i_clk),
        .i_we    (int_we),
        .i_waddr (int_waddr),
        .i_wdata (int_wdata),
        .i_re    (int_re),
        .i_raddr (int_raddr),
        .o_rdata (int_rdata)
    );

    saa_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= saa_pkg::ST_IDLE;
            r_count     <= '0;
            r_walk      <= '0;
            r_stopped   <= 1'b0;
            r_rd_idx    <= '0;
            r_sat       <= 1'b0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_walk      <= n_walk;
            r_stopped   <= n_stopped;
            r_rd_idx    <= n_rd_idx;
            r_sat       <= n_sat;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_rd_sel   <= n_rd_sel;
        r_mz       <= n_mz;
        r_int      <= n_int;
        r_rdist    <= n_rdist;
        r_tgt      <= n_tgt;
        r_out_mz   <= n_out_mz;
        r_out_int  <= n_out_int;
        r_out_last <= n_out_last;
        r_out_sat  <= n_out_sat;
        r_out_drop <= n_out_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_walk      = r_walk;
        n_stopped   = r_stopped;
        n_rd_idx    = r_rd_idx;
        n_rd_sel    = r_rd_sel;
        n_sat       = r_sat;
        n_drop      = r_drop;
        n_mz        = r_mz;
        n_int       = r_int;
        n_rdist     = r_rdist;
        n_tgt       = r_tgt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_mz    = r_out_mz;
        n_out_int   = r_out_int;
        n_out_last  = r_out_last;
        n_out_sat   = r_out_sat;
        n_out_drop  = r_out_drop;

        mz_we     = 1'b0;
        mz_waddr  = r_count[IW-1:0];
        int_we    = 1'b0;
        int_waddr = r_count[IW-1:0];
        int_wdata = i_s_tdata[63:32];
        mz_re     = 1'b0;
        mz_raddr  = r_walk[IW-1:0];
        int_re    = 1'b0;
        int_raddr = r_tgt;

        // distance is the default job of the shared unit
        alu_req.op = saa_pkg::ALU_DIFF;
        alu_req.a  = mz_rdata;
        alu_req.b  = r_mz;

        case (r_state)
            saa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (req)
                        saa_pkg::REQ_LOAD: begin
                            if (r_count < DEPTH_C) begin
                                mz_we   = 1'b1;
                                int_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        saa_pkg::REQ_APPLY: begin
                            n_walk    = app_walk;
                            n_stopped = app_stop;
                            n_mz      = i_s_tdata[31:0];
                            n_int     = i_s_tdata[63:32];
                            if (!app_stop) begin
                                if (app_walk >= r_count) begin
                                    n_stopped = 1'b1;
                                end else begin
                                    mz_re    = 1'b1;
                                    mz_raddr = app_walk[IW-1:0];
                                    n_state  = saa_pkg::ST_WALK;
                                end
                            end
                        end
                        saa_pkg::REQ_READ: begin
                            if (r_count != '0) begin
                                mz_re     = 1'b1;
                                int_re    = 1'b1;
                                mz_raddr  = rd_sel_now[IW-1:0];
                                int_raddr = rd_sel_now[IW-1:0];
                                n_rd_sel  = rd_sel_now;
                                n_state   = saa_pkg::ST_READ;
                            end
                        end
                        saa_pkg::REQ_CLEAR: begin
                            n_count   = '0;
                            n_walk    = '0;
                            n_stopped = 1'b0;
                            n_rd_idx  = '0;
                            n_sat     = 1'b0;
                            n_drop    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            saa_pkg::ST_WALK: begin
                if (alu_res.lt) begin
                    // stored m/z below the peak: step on, or stop at the end
                    n_walk = walk_inc;
                    if (walk_inc < r_count) begin
                        mz_re    = 1'b1;
                        mz_raddr = walk_inc[IW-1:0];
                    end else begin
                        n_stopped = 1'b1;
                        n_state   = saa_pkg::ST_IDLE;
                    end
                end else begin
                    n_rdist = alu_res.result;
                    if (r_walk != '0) begin
                        mz_re    = 1'b1;
                        mz_raddr = walk_dec[IW-1:0];
                        n_state  = saa_pkg::ST_LEFT;
                    end else if (alu_res.result < r_tol) begin
                        n_tgt     = r_walk[IW-1:0];
                        int_re    = 1'b1;
                        int_raddr = r_walk[IW-1:0];
                        n_state   = saa_pkg::ST_ACC;
                    end else begin
                        n_state = saa_pkg::ST_IDLE;
                    end
                end
            end
            saa_pkg::ST_LEFT: begin
                // strict compare against the right distance: a tie goes right
                if (alu_res.result < r_rdist && alu_res.result < r_tol) begin
                    n_tgt     = walk_dec[IW-1:0];
                    int_re    = 1'b1;
                    int_raddr = walk_dec[IW-1:0];
                    n_state   = saa_pkg::ST_ACC;
                end else if (r_rdist < r_tol) begin
                    n_tgt     = r_walk[IW-1:0];
                    int_re    = 1'b1;
                    int_raddr = r_walk[IW-1:0];
                    n_state   = saa_pkg::ST_ACC;
                end else begin
                    n_state = saa_pkg::ST_IDLE;
                end
            end
            saa_pkg::ST_ACC: begin
                alu_req.op = r_sub ? saa_pkg::ALU_ACC_SUB : saa_pkg::ALU_ACC_ADD;
                alu_req.a  = int_rdata;
                alu_req.b  = r_int;
                int_we     = 1'b1;
                int_waddr  = r_tgt;
                int_wdata  = alu_res.result;
                if (alu_res.sat) begin
                    n_sat = 1'b1;
                end
                n_state = saa_pkg::ST_IDLE;
            end
            saa_pkg::ST_READ: begin
                // hold the store data until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_mz    = mz_rdata;
                    n_out_int   = int_rdata;
                    n_out_last  = (rd_sel_inc == r_count);
                    n_out_sat   = r_sat;
                    n_out_drop  = r_drop;
                    n_rd_idx    = (rd_sel_inc >= r_count) ? '0 : rd_sel_inc;
                    n_state     = saa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = saa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_int, r_out_mz};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_drop, r_out_sat};

endmodule

@@ rtl/saa_checker.sv @@
// Port-level checks of the spectrum align and accumulate block, bound to
// the top level. Depends on saa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module saa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [2:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [1:0]  o_m_tuser
);

    // a stalled output beat holds its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))

    // reset empties the output register
    `ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_m_tvalid)

    // load and clear leave the sequencer idle, so the input stays open
    `ASSERT_NEXT(a_load_one, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && (i_s_tuser[1:0] == saa_pkg::REQ_LOAD), o_s_tready)
    `ASSERT_NEXT(a_clear_one, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && (i_s_tuser[1:0] == saa_pkg::REQ_CLEAR), o_s_tready)

endmodule

bind spectrum_align_accumulate saa_checker u_saa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
